FILE: hdl/base64_line_wrapped_encoder_unit_assert.svh
// Assertion macros shared by the encoder checker.
`ifndef BASE64_LINE_WRAPPED_ENCODER_UNIT_ASSERT_SVH
`define BASE64_LINE_WRAPPED_ENCODER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define B64LW_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("encoder assertion failed");

// Next-cycle implication, disabled during reset.
`define B64LW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("encoder assertion failed");

`endif

FILE: hdl/b64lw_pkg.sv
// Package: types, constants and the sextet-to-character function of the encoder.
package b64lw_pkg;

  localparam logic [7:0] LINE_FEED       = 8'h0A;
  localparam logic [7:0] PAD_CHAR        = 8'h3D;
  localparam logic [7:0] LINE_LIMIT_RST  = 8'd72;
  localparam int         MAX_CHARS       = 5;

  typedef struct packed {
    logic [15:0] held_bytes;
    logic [1:0]  group_fill;
    logic [7:0]  line_count;
  } b64lw_state_t;

  typedef struct packed {
    logic [MAX_CHARS-1:0][7:0] chars;
    logic [2:0]                n_chars;
  } b64lw_burst_t;

  // Standard alphabet: A-Z a-z 0-9 + /
  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] ch;
    if (v < 6'd26) begin
      ch = 8'(8'd65 + {2'b00, v});
    end else if (v < 6'd52) begin
      ch = 8'(8'd71 + {2'b00, v});
    end else if (v < 6'd62) begin
      ch = 8'({2'b00, v} - 8'd4);
    end else if (v == 6'd62) begin
      ch = 8'h2B;
    end else begin
      ch = 8'h2F;
    end
    return ch;
  endfunction

endpackage

FILE: hdl/b64lw_group_enc.sv
// Combinational group encoder: next state and character burst for one input byte.
module b64lw_group_enc (
  input  b64lw_pkg::b64lw_state_t state,
  input  logic [7:0]              line_limit,
  input  logic [7:0]              data_byte,
  input  logic                    is_final,
  output b64lw_pkg::b64lw_state_t state_next,
  output b64lw_pkg::b64lw_burst_t burst
);
  import b64lw_pkg::*;

  logic [7:0] b0;
  logic [7:0] b1;
  logic [8:0] sum;
  logic       lf_limit;

  assign b0       = state.held_bytes[15:8];
  assign b1       = state.held_bytes[7:0];
  assign sum      = {1'b0, state.line_count} + 9'd4;
  assign lf_limit = sum >= {1'b0, line_limit};

  always_comb begin
    state_next    = state;
    burst.chars   = '0;
    burst.n_chars = 3'd0;
    if (state.group_fill == 2'd2) begin
      // complete group
      burst.chars[0] = b64_char(b0[7:2]);
      burst.chars[1] = b64_char({b0[1:0], b1[7:4]});
      burst.chars[2] = b64_char({b1[3:0], data_byte[7:6]});
      burst.chars[3] = b64_char(data_byte[5:0]);
      burst.chars[4] = LINE_FEED;
      burst.n_chars  = (lf_limit || is_final) ? 3'd5 : 3'd4;
      state_next.held_bytes = '0;
      state_next.group_fill = 2'd0;
      state_next.line_count = (lf_limit || is_final) ? 8'd0 : sum[7:0];
    end else if (!is_final) begin
      state_next.held_bytes = (state.group_fill == 2'd0) ? {data_byte, 8'h00}
                                                         : {b0, data_byte};
      state_next.group_fill = 2'(state.group_fill + 2'd1);
    end else begin
      // partial group at end of message, always closed by a line feed
      if (state.group_fill == 2'd0) begin
        burst.chars[0] = b64_char(data_byte[7:2]);
        burst.chars[1] = b64_char({data_byte[1:0], 4'h0});
        burst.chars[2] = PAD_CHAR;
      end else begin
        burst.chars[0] = b64_char(b0[7:2]);
        burst.chars[1] = b64_char({b0[1:0], data_byte[7:4]});
        burst.chars[2] = b64_char({data_byte[3:0], 2'b00});
      end
      burst.chars[3] = PAD_CHAR;
      burst.chars[4] = LINE_FEED;
      burst.n_chars  = 3'd5;
      state_next     = '0;
    end
  end

endmodule

FILE: hdl/base64_line_wrapped_encoder_unit.sv
// Top level: Base64 encoder with line wrapping, one byte in, one character out per transfer.
// The first character of a byte's burst is valid in the cycle after the input transfer.
// Output: one character per cycle while out_stall is low, as the character buffer drains;
//   a byte produces 0, 4 or 5 characters.
// Bytes that only fill the group are taken at once, even while a burst drains.
// Reset (rst, synchronous): group and line count cleared, buffer empty, line_limit = 72.
module base64_line_wrapped_encoder_unit (
  input  logic       clk,
  input  logic       rst,
  // configuration: line_limit
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       is_final,
  // output channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       run_last,
  output logic       msg_end
);
  import b64lw_pkg::*;

  b64lw_state_t state;
  b64lw_state_t state_next;
  b64lw_burst_t burst;
  logic [7:0]   line_limit;

  // Character buffer: char_buf[0] is the one on the output; shifts down on each take.
  logic [MAX_CHARS-1:0][7:0] char_buf;
  logic [2:0]                char_cnt;
  logic                      burst_final;

  logic take;
  logic buf_free;
  logic no_output;
  logic accept;

  b64lw_group_enc u_enc (
    .state      (state),
    .line_limit (line_limit),
    .data_byte  (data_byte),
    .is_final   (is_final),
    .state_next (state_next),
    .burst      (burst)
  );

  assign take      = out_valid && !out_stall;
  // Buffer can take a new burst when empty or when its last character leaves now.
  assign buf_free  = (char_cnt == 3'd0) || ((char_cnt == 3'd1) && take);
  // A byte that only joins the group produces nothing and never waits on the buffer.
  assign no_output = (state.group_fill != 2'd2) && !is_final;
  assign in_stall  = !(buf_free || no_output);
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= '0;
      line_limit <= LINE_LIMIT_RST;
      char_cnt   <= 3'd0;
    end else begin
      if (cfg_wr_en) begin
        line_limit <= cfg_wr_data;
      end
      if (accept) begin
        state <= state_next;
      end
      if (accept && (burst.n_chars != 3'd0)) begin
        char_buf    <= burst.chars;
        char_cnt    <= burst.n_chars;
        burst_final <= is_final;
      end else if (take) begin
        for (int i = 0; i < MAX_CHARS - 1; i++) begin
          char_buf[i] <= char_buf[i+1];
        end
        char_cnt <= 3'(char_cnt - 3'd1);
      end
    end
  end

  assign out_valid = char_cnt != 3'd0;
  assign out_char  = char_buf[0];
  assign run_last  = char_cnt == 3'd1;
  assign msg_end   = (char_cnt == 3'd1) && burst_final;

endmodule

FILE: hdl/b64lw_checker.sv
// Port-level assertion checker for the encoder, bound to the top level.
`include "base64_line_wrapped_encoder_unit_assert.svh"

module b64lw_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_char,
  input logic       run_last,
  input logic       msg_end
);
  import b64lw_pkg::*;

  // stalled output transfer holds its payload
  `B64LW_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_char) && $stable(run_last) && $stable(msg_end))
  // end of message is always the end of a burst
  `B64LW_ASSERT_IMPL(a_end_is_last, out_valid && msg_end, run_last)
  // every message closes with a line feed
  `B64LW_ASSERT_IMPL(a_end_is_lf, out_valid && msg_end, out_char == LINE_FEED)
  // a burst does not break off before its last character
  `B64LW_ASSERT_NEXT(a_burst_cont, out_valid && !out_stall && !run_last, out_valid)

endmodule

bind base64_line_wrapped_encoder_unit b64lw_checker u_b64lw_checker (.*);

FILE: tb/b64lw_checker.sv
// Checker for the line-wrapped Base64 encoder: watches both channels, predicts and compares.
`timescale 1ns / 1ps

module b64lw_scoreboard (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       is_final,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_char,
  input  logic       run_last,
  input  logic       msg_end,
  output int         errors,
  output int         pending
);
  import b64lw_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       burst_end;
    logic       text_end;
  } enc_char_t;

  localparam logic [0:63][7:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  enc_char_t  char_q[$];
  enc_char_t  got_exp;
  logic [7:0] limit_r;
  logic [15:0] held_r;
  logic [1:0] fill_r;
  logic [7:0] count_r;
  int         err_cnt = 0;
  int         pend_cnt = 0;

  assign errors  = err_cnt;
  assign pending = pend_cnt;

  function automatic logic [7:0] sextet(input logic [5:0] v);
    return ALPHABET[v];
  endfunction

  // Predicts the characters one accepted byte causes and queues them.
  task automatic encode_byte(input logic [7:0] b, input logic fin);
    logic [7:0] burst [5];
    logic [7:0] b0;
    logic [7:0] b1;
    int         n;
    int         cnt;
    enc_char_t  item;
    b0  = held_r[15:8];
    b1  = held_r[7:0];
    n   = 0;
    cnt = int'(count_r);
    if (fill_r == 2'd2) begin
      burst[0] = sextet(b0[7:2]);
      burst[1] = sextet({b0[1:0], b1[7:4]});
      burst[2] = sextet({b1[3:0], b[7:6]});
      burst[3] = sextet(b[5:0]);
      n = 4;
      cnt = cnt + 4;
      if (cnt >= int'(limit_r)) begin
        burst[n] = LINE_FEED;
        n++;
        cnt = 0;
      end
      held_r = '0;
      fill_r = '0;
      // no second line feed if the wrap already ended the line
      if (fin && cnt != 0) begin
        burst[n] = LINE_FEED;
        n++;
      end
    end else if (!fin) begin
      if (fill_r == 2'd0) held_r = {b, 8'h00};
      else held_r = {b0, b};
      fill_r = fill_r + 2'd1;
    end else begin
      if (fill_r == 2'd0) begin
        burst[0] = sextet(b[7:2]);
        burst[1] = sextet({b[1:0], 4'h0});
        burst[2] = PAD_CHAR;
      end else begin
        burst[0] = sextet(b0[7:2]);
        burst[1] = sextet({b0[1:0], b[7:4]});
        burst[2] = sextet({b[3:0], 2'b00});
      end
      burst[3] = PAD_CHAR;
      burst[4] = LINE_FEED;
      n = 5;
    end
    if (fin) begin
      held_r = '0;
      fill_r = '0;
      cnt    = 0;
    end
    count_r = 8'(cnt);
    for (int i = 0; i < n; i++) begin
      item.ch        = burst[i];
      item.burst_end = (i == n - 1);
      item.text_end  = (i == n - 1) && fin;
      char_q = {char_q, item};
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      limit_r = LINE_LIMIT_RST;
      held_r  = '0;
      fill_r  = '0;
      count_r = '0;
      char_q.delete();
    end else begin
      if (cfg_wr_en) limit_r = cfg_wr_data;
      if (out_valid && !out_stall) begin
        if (char_q.size() == 0) begin
          $error("unexpected character transfer: out_char %h", out_char);
          err_cnt++;
        end else begin
          got_exp = char_q.pop_front();
          if (out_char !== got_exp.ch) begin
            $error("out_char: expected %h, actual %h", got_exp.ch, out_char);
            err_cnt++;
          end
          if (run_last !== got_exp.burst_end) begin
            $error("run_last: expected %b, actual %b", got_exp.burst_end, run_last);
            err_cnt++;
          end
          if (msg_end !== got_exp.text_end) begin
            $error("msg_end: expected %b, actual %b", got_exp.text_end, msg_end);
            err_cnt++;
          end
        end
      end
      if (in_valid && !in_stall) encode_byte(data_byte, is_final);
    end
    pend_cnt <= char_q.size();
  end

endmodule

FILE: tb/tb.sv
// Testbench top: stimulus, idling and verdict for the line-wrapped Base64 encoder.
`timescale 1ns / 1ps

module tb;

  logic       clk;
  logic       rst;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] data_byte;
  logic       is_final;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_char;
  logic       run_last;
  logic       msg_end;
  int         errors;
  int         pending;
  bit         calm = 1'b0;  // set near the end: no idling on either side

  base64_line_wrapped_encoder_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .is_final    (is_final),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_char    (out_char),
    .run_last    (run_last),
    .msg_end     (msg_end)
  );

  b64lw_scoreboard i_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .is_final    (is_final),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_char    (out_char),
    .run_last    (run_last),
    .msg_end     (msg_end),
    .errors      (errors),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Generous limit on the simulated time of the whole run.
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Receiver: random stall bursts between open stretches, none once calm is set.
  // Each pass makes one assignment and then waits on clock edges before the next pass.
  initial begin
    out_stall <= 1'b0;
    forever begin
      if (calm || $urandom_range(0, 2) != 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
  end

  // One byte transfer, with an optional idle burst in front of it.
  // Returns at the edge where the transfer happened; valid is still high,
  // so the caller drives the next byte or lowers valid in this same step.
  task automatic put_byte(input logic [7:0] b, input logic fin);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    is_final  <= fin;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop sending and wait until every predicted character has come out.
  // Bytes that only fill a group leave nothing pending, so the task keeps
  // waiting after pending reaches zero to cover the block's latency before the next write.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // line_limit is only written while the block is idle.
  task automatic set_limit(input logic [7:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Mix of extremes, the reset value and arbitrary limits.
  function automatic logic [7:0] pick_limit();
    case ($urandom_range(0, 5))
      0:       return 8'd4;
      1:       return 8'd252;
      2:       return 8'd72;
      default: return 8'($urandom_range(4, 252));
    endcase
  endfunction

  initial begin
    int sent;
    int len;
    rst         <= 1'b1;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_valid    <= 1'b0;
    data_byte   <= '0;
    is_final    <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // --- directed part, limit at its reset value of 72 ---
    // single final byte: two pads
    put_byte(8'h00, 1'b1);
    // two bytes: one pad
    put_byte(8'hFF, 1'b0);
    put_byte(8'hFF, 1'b1);
    // full group on the final byte, line not full: trailing line feed
    put_byte(8'h00, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_byte(8'h80, 1'b1);

    // limit 4: wrap after every group; a final full group gets one line feed only
    set_limit(8'd4);
    put_byte(8'hFF, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'hAA, 1'b1);
    // group wraps, then a partial group on the final byte
    put_byte(8'h12, 1'b0);
    put_byte(8'h34, 1'b0);
    put_byte(8'h56, 1'b0);
    put_byte(8'h78, 1'b1);

    // limit not a multiple of four: line runs to 8 characters
    set_limit(8'd5);
    for (int i = 0; i < 6; i++) put_byte(8'(i * 37 + 1), i == 5);

    // top of the range; also the '+' and '/' characters
    set_limit(8'd252);
    put_byte(8'hFB, 1'b0);
    put_byte(8'hEF, 1'b0);
    put_byte(8'hBE, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_byte(8'hFF, 1'b1);

    // --- random messages ---
    // Mostly short messages, some long ones so that lines fill up;
    // the limit moves between messages and now and then mid-line.
    // The last message is cut short so the whole run stays near 210 bytes.
    sent = 0;
    while (sent < 186) begin
      if ($urandom_range(0, 3) == 0) set_limit(pick_limit());
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 24);
      if (len > 186 - sent) len = 186 - sent;
      for (int k = 0; k < len; k++) begin
        if (k > 0 && $urandom_range(0, 39) == 0) set_limit(pick_limit());
        put_byte(8'($urandom_range(0, 255)), k == len - 1);
        sent++;
        if (sent >= 150) calm = 1'b1;
      end
    end

    // every character out, then a short tail for anything late
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: base64_line_wrapped_encoder_unit.f
+incdir+hdl
hdl/b64lw_pkg.sv
hdl/b64lw_group_enc.sv
hdl/base64_line_wrapped_encoder_unit.sv
hdl/b64lw_checker.sv
tb/b64lw_checker.sv
tb/tb.sv
